// File: design/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg: shared types for the integer insertion sorter
// Data type plus the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch the incoming transaction
    logic ins_rd;     // read the entry below the insertion point
    logic shift_wr;   // move that entry up one slot
    logic place_wr;   // write the new element at the insertion point
    logic set_ovf;    // store full, element dropped
    logic emit_rd;    // read the next entry to emit
    logic emit_load;  // load the output register
    logic emit_next;  // advance the emit index
    logic clear;      // set delivered, empty the store
  } isrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;         // store holds DEPTH elements
    logic pos_zero;     // insertion point at the bottom
    logic less;         // new element below the entry just read
    logic last_item;    // latched element closes the set
    logic last_result;  // output register holds the final result
  } isrt_sts_t;

endpackage

// File: design/isrt_if.sv
// ----------------------------------------------------------------------------
// isrt_if: handshake channels of the integer insertion sorter
// Input, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------

// input elements
interface isrt_in_if import isrt_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

// sorted results
interface isrt_out_if import isrt_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input overflow, output ready);
endinterface

// mode register write
interface isrt_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/isrt_ctrl.sv
// ----------------------------------------------------------------------------
// isrt_ctrl: sequencer of the integer insertion sorter
// Walks each element down the sorted store, then streams out the set.
// ----------------------------------------------------------------------------
module isrt_ctrl import isrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  isrt_sts_t sts,
  output isrt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_CMP,
    ST_RDE,
    ST_LOAD,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;

  // handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_HOLD);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_INS;
        end
      end
      ST_INS: begin
        priority if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = sts.last_item ? ST_RDE : ST_IDLE;
        end else if (sts.pos_zero) begin
          cmd.place_wr = 1'b1;
          state_nxt    = sts.last_item ? ST_RDE : ST_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.less) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = ST_INS;
        end else begin
          cmd.place_wr = 1'b1;
          state_nxt    = sts.last_item ? ST_RDE : ST_IDLE;
        end
      end
      ST_RDE: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.emit_load = 1'b1;
        state_nxt     = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready) begin
          if (sts.last_result) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = ST_RDE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/isrt_dp.sv
// ----------------------------------------------------------------------------
// isrt_dp: datapath of the integer insertion sorter
// Sorted store memory, insertion pointer, element count and output register.
// ----------------------------------------------------------------------------
module isrt_dp import isrt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  isrt_cmd_t cmd,
  output isrt_sts_t sts,
  input  data_t     in_value,
  input  logic      in_last,
  input  logic      cfg_we,
  input  logic      cfg_data,
  output data_t     out_value,
  output logic      out_last,
  output logic      out_ovf
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  data_t           mem [DEPTH];
  data_t           rdata_r;
  data_t           val_r;
  logic            last_r;
  logic [AW-1:0]   pos_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   k_r;
  logic            ovf_r;
  logic            desc_r;
  data_t           out_value_r;
  logic            out_last_r;
  logic            out_ovf_r;

  logic [CW-1:0]   emit_idx;
  logic [AW-1:0]   raddr;
  logic            rd_en;
  logic            wr_en;
  data_t           wdata;

  // emit index, reversed for descending order
  assign emit_idx = desc_r ? (count_r - CW'(1) - k_r) : k_r;
  assign raddr    = cmd.emit_rd ? emit_idx[AW-1:0] : (pos_r - AW'(1));
  assign rd_en    = cmd.emit_rd | cmd.ins_rd;

  // one write port: shift up or place the new element
  assign wr_en = cmd.shift_wr | cmd.place_wr;
  assign wdata = cmd.shift_wr ? rdata_r : val_r;

  // sorted store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_we) begin
      desc_r <= cfg_data;
    end
  end

  // count, overflow flag and emit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        k_r     <= '0;
      end else begin
        if (cmd.place_wr) count_r <= count_r + CW'(1);
        if (cmd.set_ovf)  ovf_r   <= 1'b1;
        if (cmd.emit_next) k_r    <= k_r + CW'(1);
      end
    end
  end

  // latched element and insertion pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r  <= in_value;
      last_r <= in_last;
      pos_r  <= count_r[AW-1:0];
    end else if (cmd.shift_wr) begin
      pos_r  <= pos_r - AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value_r <= rdata_r;
      out_last_r  <= (k_r + CW'(1) == count_r);
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  // status back to the controller
  assign sts.full        = (count_r == CW'(DEPTH));
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.less        = (val_r < rdata_r);
  assign sts.last_item   = last_r;
  assign sts.last_result = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above store depth");

  a_shift_needs_less: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> (sts.less && !sts.pos_zero))
    else $error("shift without a smaller new element");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rd || cmd.emit_load) |-> (count_r != '0) && (k_r < count_r))
    else $error("emit index outside stored set");

  a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_wr |-> !sts.full)
    else $error("write into a full store");

endmodule

// File: design/integer_insertion_sorter.sv
// Insertion: an accepted element is compared downward through the store, each larger entry
//   moving up one slot, until it meets no larger entry or the bottom, where it is written.
// Flow: a full store drops the element; a new element is taken only after the previous one
//   has settled or been dropped; after the final element settles, each result is read, loaded
//   into the output register and held until the sink is ready, then the next one is read.
// Reset: rst_n clears count, overflow flag, mode and controller; store not cleared.
// ----------------------------------------------------------------------------
// integer_insertion_sorter: streaming insertion sort of signed 32-bit values
// Collects a set into a sorted store and emits it ascending or descending.
// ----------------------------------------------------------------------------
module integer_insertion_sorter import isrt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  isrt_in_if.sink    in_ch,
  isrt_out_if.source out_ch,
  isrt_cfg_if.sink   cfg_ch
);

  isrt_cmd_t cmd;
  isrt_sts_t sts;

  // mode register always takes a write
  assign cfg_ch.ready = 1'b1;

  isrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  isrt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (in_ch.value),
    .in_last   (in_ch.last_in),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_value (out_ch.sorted_value),
    .out_last  (out_ch.last_out),
    .out_ovf   (out_ch.overflow)
  );

endmodule
